FILE: sv/eped_pkg.sv
// ----------------------------------------------------------------------------
// eped_pkg
// Shared types, register indexes, codes and the CORDIC arctangent table for
// the ellipse point and derivative evaluator.
// ----------------------------------------------------------------------------
package eped_pkg;

   // word widths through the datapath
   localparam int CORDIC_W    = 34;  // CORDIC x, y and residual angle
   localparam int COEF_W      = 32;  // selected sine/cosine coefficient, Q2.30
   localparam int TERM_W      = 34;  // radius times coefficient, Q18.16
   localparam int PROD_W      = 36;  // term times direction, Q20.16
   localparam int SUM_W       = 38;  // both terms plus centre
   localparam int DATA_W      = 32;
   localparam int RADIUS_W    = 31;
   localparam int RESIDUAL_W  = 30;
   localparam int CSR_INDEX_W = 4;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [DATA_W-1:0]   SAT_MAX     = 32'sh7fffffff;
   localparam logic signed [DATA_W-1:0]   SAT_MIN     = 32'sh80000000;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAJOR_DIR_X  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAJOR_DIR_Y  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MINOR_DIR_X  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MINOR_DIR_Y  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MAJOR_RADIUS = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_MINOR_RADIUS = 4'd7;

   // quadrant of the angle (top two bits)
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // derivative phase, (order - 1) mod 4
   localparam logic [1:0] PHASE_D1 = 2'd0;
   localparam logic [1:0] PHASE_D2 = 2'd1;
   localparam logic [1:0] PHASE_D3 = 2'd2;
   localparam logic [1:0] PHASE_D4 = 2'd3;

   typedef logic signed [CORDIC_W-1:0] cordic_word_type;

   typedef struct packed {
      logic [1:0] quad;
      logic       is_point;
      logic [1:0] phase;
   } item_meta_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] center_x;
      logic signed [DATA_W-1:0] center_y;
      logic signed [DATA_W-1:0] major_dir_x;
      logic signed [DATA_W-1:0] major_dir_y;
      logic signed [DATA_W-1:0] minor_dir_x;
      logic signed [DATA_W-1:0] minor_dir_y;
      logic [RADIUS_W-1:0]      major_radius;
      logic [RADIUS_W-1:0]      minor_radius;
   } geom_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic cordic_word_type atan_turn(input logic [4:0] idx);
      case (idx)
         5'd0:    atan_turn = 34'sd536870912;
         5'd1:    atan_turn = 34'sd316933406;
         5'd2:    atan_turn = 34'sd167458907;
         5'd3:    atan_turn = 34'sd85004756;
         5'd4:    atan_turn = 34'sd42667331;
         5'd5:    atan_turn = 34'sd21354465;
         5'd6:    atan_turn = 34'sd10679838;
         5'd7:    atan_turn = 34'sd5340245;
         5'd8:    atan_turn = 34'sd2670163;
         5'd9:    atan_turn = 34'sd1335087;
         5'd10:   atan_turn = 34'sd667544;
         5'd11:   atan_turn = 34'sd333772;
         5'd12:   atan_turn = 34'sd166886;
         5'd13:   atan_turn = 34'sd83443;
         5'd14:   atan_turn = 34'sd41722;
         5'd15:   atan_turn = 34'sd20861;
         5'd16:   atan_turn = 34'sd10430;
         5'd17:   atan_turn = 34'sd5215;
         5'd18:   atan_turn = 34'sd2608;
         5'd19:   atan_turn = 34'sd1304;
         5'd20:   atan_turn = 34'sd652;
         5'd21:   atan_turn = 34'sd326;
         5'd22:   atan_turn = 34'sd163;
         5'd23:   atan_turn = 34'sd81;
         5'd24:   atan_turn = 34'sd41;
         5'd25:   atan_turn = 34'sd20;
         5'd26:   atan_turn = 34'sd10;
         5'd27:   atan_turn = 34'sd5;
         5'd28:   atan_turn = 34'sd3;
         5'd29:   atan_turn = 34'sd1;
         5'd30:   atan_turn = 34'sd1;
         default: atan_turn = 34'sd0;
      endcase
   endfunction

endpackage

FILE: sv/ellipse_point_derivative_eval_unit.sv
// ----------------------------------------------------------------------------
// ellipse_point_derivative_eval_unit
// Evaluates a configured ellipse, or one of its derivatives, at one angle
// per request.
// ----------------------------------------------------------------------------
// Usage:
//   Write the centre, axis directions and radii over the csr_ channel while
//   no request is in flight; csr_ready is always high and unknown indexes
//   are dropped.
//   Send one request per cycle on req_: angle (2^32 is a full turn) and
//   derivative order (0 gives the point). Each request gives one response
//   on rsp_ with the Q16.16 vector and a flag set when it was clipped.
//   From acceptance to rsp_valid a request passes an input register, one
//   stage per CORDIC iteration, then coefficient select, two multiply
//   stages and the sum/saturate result register. Throughput is one request
//   per cycle while the response is taken, set by the fully unrolled CORDIC.
//   Every stage holds its own valid bit; a stalled receiver holds the
//   response and the stages fill up behind it, so req_ready falls only once
//   every stage is occupied.
//   Reset empties the pipeline and returns the registers to a unit circle
//   at the origin.
// ----------------------------------------------------------------------------
module ellipse_point_derivative_eval_unit
   import eped_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = 24
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [DATA_W-1:0]        req_angle,
   input  logic [7:0]               req_deriv_order,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_out_x,
   output logic signed [DATA_W-1:0] rsp_out_y,
   output logic                     rsp_saturated,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   geom_type geom_ff;

   logic                  in_vld_ff;
   item_meta_type         in_meta_ff, in_meta_in;
   logic [RESIDUAL_W-1:0] in_residual_ff;
   logic                  in_en;

   logic                  cordic_in_en;
   logic                  cordic_vld;
   item_meta_type         cordic_meta;
   cordic_word_type       cordic_cos, cordic_sin;
   logic                  scale_in_en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.center_x     <= '0;
         geom_ff.center_y     <= '0;
         geom_ff.major_dir_x  <= 32'sh40000000;
         geom_ff.major_dir_y  <= '0;
         geom_ff.minor_dir_x  <= '0;
         geom_ff.minor_dir_y  <= 32'sh40000000;
         geom_ff.major_radius <= 31'd65536;
         geom_ff.minor_radius <= 31'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CENTER_X:     geom_ff.center_x     <= csr_data;
            REG_CENTER_Y:     geom_ff.center_y     <= csr_data;
            REG_MAJOR_DIR_X:  geom_ff.major_dir_x  <= csr_data;
            REG_MAJOR_DIR_Y:  geom_ff.major_dir_y  <= csr_data;
            REG_MINOR_DIR_X:  geom_ff.minor_dir_x  <= csr_data;
            REG_MINOR_DIR_Y:  geom_ff.minor_dir_y  <= csr_data;
            REG_MAJOR_RADIUS: geom_ff.major_radius <= csr_data[RADIUS_W-1:0];
            REG_MINOR_RADIUS: geom_ff.minor_radius <= csr_data[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // input register: split angle into quadrant and residual
   assign in_en     = !in_vld_ff || cordic_in_en;
   assign req_ready = in_en;

   always_comb begin
      in_meta_in.quad     = req_angle[DATA_W-1:RESIDUAL_W];
      in_meta_in.is_point = (req_deriv_order == 8'd0);
      in_meta_in.phase    = 2'(req_deriv_order[1:0] - 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_en) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         in_meta_ff     <= in_meta_in;
         in_residual_ff <= req_angle[RESIDUAL_W-1:0];
      end
   end

   eped_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock       (clock),
      .reset       (reset),
      .in_vld      (in_vld_ff),
      .in_meta     (in_meta_ff),
      .in_residual (in_residual_ff),
      .in_en       (cordic_in_en),
      .out_en      (scale_in_en),
      .out_vld     (cordic_vld),
      .out_meta    (cordic_meta),
      .out_cos     (cordic_cos),
      .out_sin     (cordic_sin)
   );

   eped_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .geom          (geom_ff),
      .in_vld        (cordic_vld),
      .in_meta       (cordic_meta),
      .in_cos        (cordic_cos),
      .in_sin        (cordic_sin),
      .in_en         (scale_in_en),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_saturated (rsp_saturated)
   );

`ifndef ASSERT_OFF
   // back-pressure reaches the input only through a stalled response
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request refused while response side is free");

   // a clipped response carries a range limit in one component
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_out_x == SAT_MAX || rsp_out_x == SAT_MIN ||
          rsp_out_y == SAT_MAX || rsp_out_y == SAT_MIN))
      else $error("saturation flag without clipped component");

   // reset leaves no response pending
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");
`endif

endmodule

FILE: sv/eped_cordic.sv
// ----------------------------------------------------------------------------
// eped_cordic
// Unrolled rotation-mode CORDIC, one iteration per register stage, giving
// cosine and sine of the residual angle in Q4.30.
// ----------------------------------------------------------------------------
module eped_cordic
   import eped_pkg::*;
#(
   parameter int ITERATIONS = 24
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  item_meta_type         in_meta,
   input  logic [RESIDUAL_W-1:0] in_residual,
   output logic                  in_en,
   input  logic                  out_en,
   output logic                  out_vld,
   output item_meta_type         out_meta,
   output cordic_word_type       out_cos,
   output cordic_word_type       out_sin
);

   cordic_word_type x_ff [ITERATIONS];
   cordic_word_type y_ff [ITERATIONS];
   cordic_word_type z_ff [ITERATIONS-1];
   item_meta_type   meta_ff [ITERATIONS];
   logic [ITERATIONS-1:0] vld_ff;

   cordic_word_type src_x [ITERATIONS];
   cordic_word_type src_y [ITERATIONS];
   cordic_word_type src_z [ITERATIONS];
   item_meta_type   src_meta [ITERATIONS];
   logic [ITERATIONS-1:0] src_vld;

   cordic_word_type x_in [ITERATIONS];
   cordic_word_type y_in [ITERATIONS];
   cordic_word_type z_in [ITERATIONS];

   logic [ITERATIONS:0] en;

   // a stage loads when it is empty or its successor moves on
   assign en[ITERATIONS] = out_en;
   for (genvar g = 0; g < ITERATIONS; g++) begin : g_en
      assign en[g] = !vld_ff[g] || en[g+1];
   end
   assign in_en = en[0];

   always_comb begin
      src_x[0]    = CORDIC_GAIN;
      src_y[0]    = '0;
      src_z[0]    = CORDIC_W'(in_residual);
      src_meta[0] = in_meta;
      src_vld[0]  = in_vld;
      for (int i = 1; i < ITERATIONS; i++) begin
         src_x[i]    = x_ff[i-1];
         src_y[i]    = y_ff[i-1];
         src_z[i]    = z_ff[i-1];
         src_meta[i] = meta_ff[i-1];
         src_vld[i]  = vld_ff[i-1];
      end
   end

   // rotate towards zero residual; shifts floor
   always_comb begin
      for (int i = 0; i < ITERATIONS; i++) begin
         if (!src_z[i][CORDIC_W-1]) begin
            x_in[i] = src_x[i] - (src_y[i] >>> i);
            y_in[i] = src_y[i] + (src_x[i] >>> i);
            z_in[i] = src_z[i] - atan_turn(5'(i));
         end else begin
            x_in[i] = src_x[i] + (src_y[i] >>> i);
            y_in[i] = src_y[i] - (src_x[i] >>> i);
            z_in[i] = src_z[i] + atan_turn(5'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < ITERATIONS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= src_vld[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ITERATIONS; i++) begin
         if (en[i]) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            meta_ff[i] <= src_meta[i];
         end
      end
      for (int i = 0; i < ITERATIONS - 1; i++) begin
         if (en[i]) begin
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign out_vld  = vld_ff[ITERATIONS-1];
   assign out_meta = meta_ff[ITERATIONS-1];
   assign out_cos  = x_ff[ITERATIONS-1];
   assign out_sin  = y_ff[ITERATIONS-1];

endmodule

FILE: sv/eped_scale.sv
// ----------------------------------------------------------------------------
// eped_scale
// Coefficient selection, radius and direction products, centre offset and
// saturation, ending in the result register.
// ----------------------------------------------------------------------------
module eped_scale
   import eped_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  geom_type                 geom,
   input  logic                     in_vld,
   input  item_meta_type            in_meta,
   input  cordic_word_type          in_cos,
   input  cordic_word_type          in_sin,
   output logic                     in_en,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_out_x,
   output logic signed [DATA_W-1:0] rsp_out_y,
   output logic                     rsp_saturated
);

   localparam logic signed [63:0] HALF_64 = 64'sd536870912;
   localparam logic signed [65:0] HALF_66 = 66'sd536870912;

   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic en_a, en_b, en_c, en_d;

   // stage A: quadrant and derivative phase pick the coefficients
   cordic_word_type c_val, s_val, a_val, b_val;
   logic signed [COEF_W-1:0] coef_a_ff, coef_b_ff;
   logic a_pt_ff;

   // stage B: radius times coefficient
   logic signed [63:0] prod_a, prod_b;
   logic signed [TERM_W-1:0] term_a_ff, term_b_ff, term_a_in, term_b_in;
   logic b_pt_ff;

   // stage C: term times direction
   logic signed [65:0] pxa, pxb, pya, pyb;
   logic signed [PROD_W-1:0] pxa_ff, pxb_ff, pya_ff, pyb_ff;
   logic c_pt_ff;

   // stage D: sum and clip
   logic signed [SUM_W-1:0] off_x, off_y, sum_x, sum_y;
   logic clip_x, clip_y;
   logic signed [DATA_W-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic sat_ff;

   assign en_d  = !d_vld_ff || rsp_ready;
   assign en_c  = !c_vld_ff || en_d;
   assign en_b  = !b_vld_ff || en_c;
   assign en_a  = !a_vld_ff || en_b;
   assign in_en = en_a;

   always_comb begin
      case (in_meta.quad)
         QUAD_0: begin
            c_val = in_cos;
            s_val = in_sin;
         end
         QUAD_1: begin
            c_val = -in_sin;
            s_val = in_cos;
         end
         QUAD_2: begin
            c_val = -in_cos;
            s_val = -in_sin;
         end
         default: begin
            c_val = in_sin;
            s_val = -in_cos;
         end
      endcase
      if (in_meta.is_point) begin
         a_val = c_val;
         b_val = s_val;
      end else begin
         case (in_meta.phase)
            PHASE_D1: begin
               a_val = -s_val;
               b_val = c_val;
            end
            PHASE_D2: begin
               a_val = -c_val;
               b_val = -s_val;
            end
            PHASE_D3: begin
               a_val = s_val;
               b_val = -c_val;
            end
            default: begin
               a_val = c_val;
               b_val = s_val;
            end
         endcase
      end
   end

   assign prod_a    = $signed({1'b0, geom.major_radius}) * coef_a_ff;
   assign prod_b    = $signed({1'b0, geom.minor_radius}) * coef_b_ff;
   assign term_a_in = TERM_W'((prod_a + HALF_64) >>> 30);
   assign term_b_in = TERM_W'((prod_b + HALF_64) >>> 30);

   assign pxa = term_a_ff * geom.major_dir_x;
   assign pxb = term_b_ff * geom.minor_dir_x;
   assign pya = term_a_ff * geom.major_dir_y;
   assign pyb = term_b_ff * geom.minor_dir_y;

   // add the centre only for the point itself
   assign off_x = c_pt_ff ? SUM_W'(geom.center_x) : '0;
   assign off_y = c_pt_ff ? SUM_W'(geom.center_y) : '0;
   assign sum_x = SUM_W'(pxa_ff) + SUM_W'(pxb_ff) + off_x;
   assign sum_y = SUM_W'(pya_ff) + SUM_W'(pyb_ff) + off_y;

   // out of range when the bits above bit 30 are not all sign
   assign clip_x = !((&sum_x[SUM_W-1:DATA_W-1]) || !(|sum_x[SUM_W-1:DATA_W-1]));
   assign clip_y = !((&sum_y[SUM_W-1:DATA_W-1]) || !(|sum_y[SUM_W-1:DATA_W-1]));

   always_comb begin
      if (clip_x) begin
         out_x_in = sum_x[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         out_x_in = DATA_W'(sum_x);
      end
      if (clip_y) begin
         out_y_in = sum_y[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         out_y_in = DATA_W'(sum_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_vld_ff <= in_vld;
         end
         if (en_b) begin
            b_vld_ff <= a_vld_ff;
         end
         if (en_c) begin
            c_vld_ff <= b_vld_ff;
         end
         if (en_d) begin
            d_vld_ff <= c_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         coef_a_ff <= COEF_W'(a_val);
         coef_b_ff <= COEF_W'(b_val);
         a_pt_ff   <= in_meta.is_point;
      end
      if (en_b) begin
         term_a_ff <= term_a_in;
         term_b_ff <= term_b_in;
         b_pt_ff   <= a_pt_ff;
      end
      if (en_c) begin
         pxa_ff  <= PROD_W'((pxa + HALF_66) >>> 30);
         pxb_ff  <= PROD_W'((pxb + HALF_66) >>> 30);
         pya_ff  <= PROD_W'((pya + HALF_66) >>> 30);
         pyb_ff  <= PROD_W'((pyb + HALF_66) >>> 30);
         c_pt_ff <= b_pt_ff;
      end
      if (en_d) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         sat_ff   <= clip_x || clip_y;
      end
   end

   assign rsp_valid     = d_vld_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_saturated = sat_ff;

endmodule
